// ===== rtl/sha_pkg.sv =====
// Package with SHA-256 types, constants and a rotate-right function.
package sha_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  localparam logic OpAbsorb   = 1'b0;
  localparam logic OpFinalize = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_byte;     // write data into buffer at fill position
    logic [7:0] wr_data;
    logic       pad_byte;    // write 0x80 at fill position, zero the rest of the word
    logic       zero_word;   // write zero into word wr_word
    logic       len_word;    // write a length word into word wr_word
    logic [3:0] wr_word;
    logic       comp_start;  // load schedule and round variables
    logic       comp_round;  // run one round
    logic       comp_add;    // add round variables into chaining value
    logic       len_inc;     // add 8 to the bit length
    logic       restart;     // back to initial chaining value, length and fill
    logic       shift_out;   // rotate chaining value by one word for output
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
  } sha_sts_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [5:0] PadLimit = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/sha256_streaming_hasher.sv =====
// Top level of the streaming SHA-256 engine.
// Input channel: in_valid_i/in_ready_o with in_data_i (opcode, data_byte).
// An absorb transfer appends one byte; every 64th byte
// starts a compression (load, 64 rounds on one round unit, add)
// during which in_ready_o is low.
// A finalize transfer pads the block, runs one or two compressions (two when
// 56 or more bytes are held), then sends eight digest words H0..H7 on the
// output channel out_valid_o/out_ready_i with out_data_o; the eighth word
// carries last_word. Before the first word come zero fill, length load and
// compression (for two blocks, after a first compression of the padded block);
// words follow one per cycle while the receiver is ready.
// If the receiver stalls, the output register holds its word and the
// engine waits; no input is taken until all eight words are sent.
// After the digest the engine returns to the initial hash state.
// Reset (rst_ni low) restores the initial chaining value, zero length and
// an empty block buffer.
module sha256_streaming_hasher import sha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sha_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sha_out_t out_data_o
);

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [31:0] h0;

  sha_control u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cmd_o(cmd), .sts_i(sts), .h0_i(h0)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .h0_o(h0)
  );

`ifndef ASSERT_OFF
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during digest output");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.wr_byte, cmd.pad_byte, cmd.zero_word, cmd.len_word,
              cmd.comp_start, cmd.comp_round, cmd.comp_add}))
    else $error("conflicting datapath commands");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd7)))
    else $error("last flag mismatch");
`endif

endmodule

// ===== rtl/sha_datapath.sv =====
// Datapath: block buffer, message schedule, round variables and chaining value.
module sha_datapath import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha_cmd_t    cmd_i,
  output sha_sts_t    sts_o,
  output logic [31:0] h0_o
);

  logic [31:0] buf_q [16];
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  round_q;
  logic [63:0] len_q;

  logic [3:0]  fw;
  logic [1:0]  fb;
  logic [31:0] w_cur, w_new, s0, s1, t1, t2, ch, maj, sig0, sig1;
  logic [31:0] pad_mask, pad_val;

  assign fw = fill_q[5:2];
  assign fb = fill_q[1:0];

  // Bytes at and after the pad position in the current word are cleared.
  always_comb begin
    unique case (fb)
      2'd0: begin pad_mask = 32'h0000_0000; pad_val = 32'h8000_0000; end
      2'd1: begin pad_mask = 32'hff00_0000; pad_val = 32'h0080_0000; end
      2'd2: begin pad_mask = 32'hffff_0000; pad_val = 32'h0000_8000; end
      default: begin pad_mask = 32'hffff_ff00; pad_val = 32'h0000_0080; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      unique case (fb)
        2'd0: buf_q[fw][31:24] <= cmd_i.wr_data;
        2'd1: buf_q[fw][23:16] <= cmd_i.wr_data;
        2'd2: buf_q[fw][15:8]  <= cmd_i.wr_data;
        default: buf_q[fw][7:0] <= cmd_i.wr_data;
      endcase
    end else if (cmd_i.pad_byte) begin
      buf_q[fw] <= (buf_q[fw] & pad_mask) | pad_val;
    end else if (cmd_i.zero_word) begin
      buf_q[cmd_i.wr_word] <= '0;
    end else if (cmd_i.len_word) begin
      buf_q[cmd_i.wr_word] <= cmd_i.wr_word[0] ? len_q[31:0] : len_q[63:32];
    end
  end

  // Schedule window shifts by one word per round; entry 0 is w[t].
  assign sig0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign sig1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = sig1 + w_q[9] + sig0 + w_q[0];
  assign w_cur = w_q[0];

  assign s1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign s0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + s1 + ch + RoundK[round_q] + w_cur;
  assign t2  = s0 + maj;

  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= buf_q[i];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.comp_round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      // Entry 15 holds w[t+16], computed from the current window.
      w_q[15] <= w_new;
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.restart) fill_d = '0;
    else if (cmd_i.wr_byte) fill_d = fill_q + 6'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      round_q <= '0;
      len_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      fill_q <= fill_d;
      if (cmd_i.comp_start) round_q <= '0;
      else if (cmd_i.comp_round) round_q <= round_q + 6'd1;
      if (cmd_i.restart) len_q <= '0;
      else if (cmd_i.len_inc) len_q <= len_q + 64'd8;
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
      end else if (cmd_i.comp_add) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end else if (cmd_i.shift_out) begin
        for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
        h_q[7] <= h_q[0];
      end
    end
  end

  assign sts_o.fill  = fill_q;
  assign sts_o.round = round_q;
  assign h0_o = h_q[0];

endmodule

// ===== rtl/sha_control.sv =====
// Controller state machine sequencing absorb, padding, compression and output.
module sha_control import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sha_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sha_out_t    out_data_o,
  output sha_cmd_t    cmd_o,
  input  sha_sts_t    sts_i,
  input  logic [31:0] h0_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StZero  = 3'd4;
  localparam logic [2:0] StLoad  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [3:0] word_q, word_d;   // zero-fill / output word counter
  logic       fin_q, fin_d;     // compressing as part of finalize
  logic       last_q, last_d;   // this compression carries the length
  logic       ov_q, ov_d;
  sha_out_t   out_q, out_d;
  logic       acc;

  // The last digest word must leave before a new transfer is taken.
  assign in_ready_o = (state_q == StIdle) && !ov_q;
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    fin_d   = fin_q;
    last_d  = last_q;
    ov_d    = ov_q;
    out_d   = out_q;
    cmd_o   = '0;
    cmd_o.wr_data = in_data_i.data_byte;
    cmd_o.wr_word = word_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (in_data_i.opcode == OpAbsorb) begin
            cmd_o.wr_byte = 1'b1;
            cmd_o.len_inc = 1'b1;
            fin_d = 1'b0;
            last_d = 1'b0;
            if (sts_i.fill == 6'd63) state_d = StStart;
          end else begin
            cmd_o.pad_byte = 1'b1;
            fin_d = 1'b1;
            last_d = (sts_i.fill < PadLimit);
            word_d = sts_i.fill[5:2] + 4'd1;
            state_d = (sts_i.fill[5:2] == 4'd15) ? StStart : StZero;
          end
        end
      end
      StZero: begin
        // Clear words after the pad word up to 13, or 15 if no length follows.
        if (word_q[3:2] == 2'b11 && word_q[1] && last_q) begin
          state_d = StLoad;
        end else begin
          cmd_o.zero_word = 1'b1;
          word_d = word_q + 4'd1;
          if (word_q == 4'd15) state_d = StStart;
        end
      end
      StLoad: begin
        cmd_o.len_word = 1'b1;
        word_d = word_q + 4'd1;
        if (word_q == 4'd15) state_d = StStart;
      end
      StStart: begin
        cmd_o.comp_start = 1'b1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.comp_round = 1'b1;
        if (sts_i.round == 6'd63) state_d = StAdd;
      end
      StAdd: begin
        cmd_o.comp_add = 1'b1;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (!last_q) begin
          // Second block: zeros and the length.
          last_d = 1'b1;
          word_d = '0;
          state_d = StZero;
        end else begin
          word_d = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          out_d.digest_word = h0_i;
          out_d.word_index  = word_q[2:0];
          out_d.last_word   = (word_q[2:0] == 3'd7);
          cmd_o.shift_out = 1'b1;
          word_d = word_q + 4'd1;
          if (word_q[2:0] == 3'd7) begin
            state_d = StIdle;
            cmd_o.shift_out = 1'b0;
            cmd_o.restart = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      word_q  <= '0;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      fin_q   <= fin_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
